// ===== hdl/probing_hash_table_top_macros.svh =====
`ifndef PROBING_HASH_TABLE_TOP_MACROS_SVH
`define PROBING_HASH_TABLE_TOP_MACROS_SVH

// Assertion helpers. Each expects signals named clock and reset in scope.

`define PHT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define PHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pht_pkg.sv =====
`default_nettype none

package pht_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 34;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int DIGIT_W  = 4;

   localparam logic [OP_W-1:0] OP_INS_LINEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_INS_QUAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH     = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE     = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic hash_step;
      logic probe_start;
      logic probe_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hash_last;
      logic eval_end;
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/probing_hash_table_top.sv =====
// Open-addressing hash table of TABLE_SIZE slots, keyed by a 34-bit phone number.
// Request channel: req_valid/req_stall with req_operation, req_phone_key and
// req_entry_data. A request is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid/rsp_stall with rsp_status, rsp_slot_index,
// rsp_found_data and rsp_collided; every request yields exactly one response.
// One request is handled at a time. A request is taken, then its home slot is formed
// (key mod TABLE_SIZE, four key bits per cycle), then the slot memories are probed
// (one slot read per cycle through a registered read port), and finally the
// result is handed to the output register.
// Inserts and searches stop at the first usable slot; deletes always scan all.
// After reset the block clears every slot of the valid memory, one slot per cycle,
// while req_stall stays high; stored keys and data are left.
// A finished response waits in the output register while rsp_stall is high, and
// the next request may already be taken and processed behind it.
`default_nettype none

module probing_hash_table_top #(
   parameter int TABLE_SIZE = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pht_pkg::OP_W-1:0]      req_operation,
   input  wire logic [pht_pkg::KEY_W-1:0]     req_phone_key,
   input  wire logic [pht_pkg::DATA_W-1:0]    req_entry_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [pht_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [pht_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic      [pht_pkg::DATA_W-1:0]    rsp_found_data,
   output logic                               rsp_collided
);

   import pht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pht_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_operation),
      .req_phone_key  (req_phone_key),
      .req_entry_data (req_entry_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_found_data (rsp_found_data),
      .rsp_collided   (rsp_collided)
   );

endmodule

`default_nettype wire

// ===== hdl/pht_ram.sv =====
`default_nettype none

module pht_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pht_ctrl.sv =====
`default_nettype none

`include "probing_hash_table_top_macros.svh"

module pht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pht_pkg::stat_type stat,
   output pht_pkg::cmd_type       cmd
);

   import pht_pkg::*;

   typedef enum logic [2:0] {
      CLEAR_ST,
      IDLE_ST,
      HASH_ST,
      PROBE_ST,
      FINISH_ST
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         CLEAR_ST: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = IDLE_ST;
            end
         end
         IDLE_ST: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = HASH_ST;
            end
         end
         HASH_ST: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_last) begin
               cmd.probe_start = 1'b1;
               state_in        = PROBE_ST;
            end
         end
         PROBE_ST: begin
            cmd.probe_step = 1'b1;
            if (stat.eval_end) begin
               state_in = FINISH_ST;
            end
         end
         FINISH_ST: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = IDLE_ST;
            end
         end
         default: begin
            state_in = CLEAR_ST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR_ST;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE_ST);

   `PHT_ASSERT_NEXT(a_clear_once, state_ff != CLEAR_ST, state_ff != CLEAR_ST, "clear pass restarted")

endmodule

`default_nettype wire

// ===== hdl/pht_datapath.sv =====
`default_nettype none

`include "probing_hash_table_top_macros.svh"

module pht_datapath #(
   parameter int TABLE_SIZE = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pht_pkg::cmd_type              cmd,
   output pht_pkg::stat_type                  stat,
   input  wire logic [pht_pkg::OP_W-1:0]      req_operation,
   input  wire logic [pht_pkg::KEY_W-1:0]     req_phone_key,
   input  wire logic [pht_pkg::DATA_W-1:0]    req_entry_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [pht_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [pht_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic      [pht_pkg::DATA_W-1:0]    rsp_found_data,
   output logic                               rsp_collided
);

   import pht_pkg::*;

   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
   localparam int HASH_CYCLES = (KEY_W + DIGIT_W - 1) / DIGIT_W;
   localparam int SHIFT_W     = HASH_CYCLES * DIGIT_W;
   localparam int HCNT_W      = $clog2(HASH_CYCLES);
   localparam int KD_W        = KEY_W + DATA_W;

   localparam logic [IDX_W:0]    SIZE_X    = (IDX_W + 1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0]  SIZE_CNT  = CNT_W'(TABLE_SIZE);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_SIZE - 1);
   localparam logic [HCNT_W-1:0] LAST_HCNT = HCNT_W'(HASH_CYCLES - 1);

   function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SIZE_X) begin
         s = s - SIZE_X;
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] add_two(input logic [IDX_W-1:0] a);
      logic [IDX_W:0] s;
      s = {1'b0, a} + (IDX_W + 1)'(2);
      if (s >= SIZE_X) begin
         s = s - SIZE_X;
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] mod_digit(input logic [IDX_W-1:0]   rem,
                                                  input logic [DIGIT_W-1:0] digit);
      logic [IDX_W:0] r;
      r = {1'b0, rem};
      for (int b = DIGIT_W - 1; b >= 0; b--) begin
         r = {r[IDX_W-1:0], digit[b]};
         if (r >= SIZE_X) begin
            r = r - SIZE_X;
         end
      end
      return r[IDX_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] a);
      logic [IDX_W+SLOT_W-1:0] w;
      w = {{SLOT_W{1'b0}}, a};
      return w[SLOT_W-1:0];
   endfunction

   logic [OP_W-1:0]     op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [SHIFT_W-1:0]  shift_ff;
   logic [HCNT_W-1:0]   hcnt_ff;
   logic [IDX_W-1:0]    home_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [IDX_W-1:0]    off_ff;
   logic [IDX_W-1:0]    step_ff;
   logic                eval_valid_ff;
   logic [IDX_W-1:0]    eval_addr_ff;
   logic                eval_last_ff;
   logic                del_hit_ff;
   logic [IDX_W-1:0]    del_first_ff;
   logic [IDX_W-1:0]    clear_cnt_ff;
   logic [STATUS_W-1:0] pend_status_ff;
   logic [SLOT_W-1:0]   pend_slot_ff;
   logic [DATA_W-1:0]   pend_data_ff;
   logic                pend_col_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic                rsp_col_ff;

   logic [STATUS_W-1:0] pend_status_in;
   logic [SLOT_W-1:0]   pend_slot_in;
   logic [DATA_W-1:0]   pend_data_in;
   logic                pend_col_in;

   logic                is_scan;
   logic [IDX_W-1:0]    probe_addr;
   logic                issue;
   logic [0:0]          vld_q;
   logic [KD_W-1:0]     kd_q;
   logic [KEY_W-1:0]    key_q;
   logic [DATA_W-1:0]   data_q;
   logic                match;
   logic                hit;
   logic                eval_end;
   logic                eval_act;
   logic                ins_wr;
   logic                del_wr;
   logic                del_any;
   logic [IDX_W-1:0]    del_first;
   logic                vld_wr_en;
   logic [IDX_W-1:0]    vld_wr_addr;
   logic [0:0]          vld_wr_data;
   logic                kd_wr_en;

   assign is_scan    = (op_ff == OP_SEARCH) || (op_ff == OP_DELETE);
   assign probe_addr = is_scan ? cnt_ff[IDX_W-1:0] : add_mod(home_ff, off_ff);
   assign issue      = (cnt_ff != SIZE_CNT);

   assign key_q  = kd_q[KD_W-1:DATA_W];
   assign data_q = kd_q[DATA_W-1:0];
   assign match  = vld_q[0] && (key_q == key_ff);
   assign hit    = is_scan ? match : !vld_q[0];

   assign eval_end = eval_valid_ff && ((hit && (op_ff != OP_DELETE)) || eval_last_ff);
   assign eval_act = cmd.probe_step && eval_valid_ff;
   assign ins_wr   = eval_act && !is_scan && hit;
   assign del_wr   = eval_act && (op_ff == OP_DELETE) && match;

   assign del_any   = del_hit_ff || match;
   assign del_first = del_hit_ff ? del_first_ff : eval_addr_ff;

   assign vld_wr_en   = cmd.clear_step || ins_wr || del_wr;
   assign vld_wr_addr = cmd.clear_step ? clear_cnt_ff : eval_addr_ff;
   assign vld_wr_data = ins_wr;
   assign kd_wr_en    = ins_wr;

   pht_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_SIZE)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_wr_en),
      .wr_addr (vld_wr_addr),
      .wr_data (vld_wr_data),
      .rd_addr (probe_addr),
      .rd_data (vld_q)
   );

   pht_ram #(
      .WIDTH (KD_W),
      .DEPTH (TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (kd_wr_en),
      .wr_addr (eval_addr_ff),
      .wr_data ({key_ff, data_ff}),
      .rd_addr (probe_addr),
      .rd_data (kd_q)
   );

   always_comb begin
      pend_status_in = ST_OK;
      pend_slot_in   = '0;
      pend_data_in   = '0;
      pend_col_in    = 1'b0;
      case (op_ff)
         OP_INS_LINEAR, OP_INS_QUAD: begin
            if (hit) begin
               pend_slot_in = to_slot(eval_addr_ff);
               pend_col_in  = (eval_addr_ff != home_ff);
            end else begin
               pend_status_in = ST_FULL;
            end
         end
         OP_SEARCH: begin
            if (match) begin
               pend_slot_in = to_slot(eval_addr_ff);
               pend_data_in = data_q;
            end else begin
               pend_status_in = ST_NOT_FOUND;
            end
         end
         OP_DELETE: begin
            if (del_any) begin
               pend_slot_in = to_slot(del_first);
            end else begin
               pend_status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            pend_status_in = ST_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         key_ff   <= req_phone_key;
         data_ff  <= req_entry_data;
         shift_ff <= SHIFT_W'(req_phone_key);
         hcnt_ff  <= '0;
         home_ff  <= '0;
      end else if (cmd.hash_step) begin
         home_ff  <= mod_digit(home_ff, shift_ff[SHIFT_W-1 -: DIGIT_W]);
         shift_ff <= shift_ff << DIGIT_W;
         hcnt_ff  <= hcnt_ff + 1'b1;
      end

      if (cmd.probe_start) begin
         off_ff  <= '0;
         step_ff <= IDX_W'(1);
      end else if (cmd.probe_step && issue) begin
         off_ff       <= add_mod(off_ff, step_ff);
         step_ff      <= (op_ff == OP_INS_QUAD) ? add_two(step_ff) : step_ff;
         eval_addr_ff <= probe_addr;
         eval_last_ff <= (cnt_ff == LAST_CNT);
      end

      if (cmd.probe_start) begin
         del_hit_ff <= 1'b0;
      end else if (del_wr && !del_hit_ff) begin
         del_hit_ff   <= 1'b1;
         del_first_ff <= eval_addr_ff;
      end

      if (cmd.probe_step && eval_end) begin
         pend_status_ff <= pend_status_in;
         pend_slot_ff   <= pend_slot_in;
         pend_data_ff   <= pend_data_in;
         pend_col_ff    <= pend_col_in;
      end

      if (cmd.rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_slot_ff   <= pend_slot_ff;
         rsp_data_ff   <= pend_data_ff;
         rsp_col_ff    <= pend_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= SIZE_CNT;
         eval_valid_ff <= 1'b0;
         clear_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.probe_start) begin
            cnt_ff        <= '0;
            eval_valid_ff <= 1'b0;
         end else if (cmd.probe_step) begin
            if (issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            eval_valid_ff <= issue;
         end
         if (cmd.clear_step) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.clear_last = (clear_cnt_ff == LAST_IDX);
   assign stat.hash_last  = (hcnt_ff == LAST_HCNT);
   assign stat.eval_end   = eval_end;
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_found_data = rsp_data_ff;
   assign rsp_collided   = rsp_col_ff;

   `PHT_ASSERT_ALWAYS(a_entry_write_sets_valid, !kd_wr_en || (vld_wr_en && vld_wr_data[0]), "entry written without valid")
   `PHT_ASSERT_ALWAYS(a_delete_full_scan, !(eval_end && (op_ff == OP_DELETE)) || eval_last_ff, "delete ended early")
   `PHT_ASSERT_ALWAYS(a_probe_count_bound, cnt_ff <= SIZE_CNT, "probe count overran table")
   `PHT_ASSERT_ALWAYS(a_no_result_overrun, !cmd.rsp_load || !(rsp_valid_ff && rsp_stall), "stalled response overwritten")

endmodule

`default_nettype wire
